// ----- sv/clfp_pkg.sv -----
// Shared types for the canonical line core: controller/datapath command and
// status bundles and the divider operand select. No dependencies.
package clfp_pkg;

  // Which coefficient the serial divider is working on
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C
  } div_sel_e;

  typedef struct packed {
    logic      load;       // capture the point coordinates
    logic      mul;        // form both cross products and the differences a and b
    logic      diff;       // form c from the products
    logic      flip;       // sign normalize, split into magnitude and sign
    logic      g1_start;   // gcd(|a|, |b|)
    logic      g2_start;   // gcd(previous, |c|)
    logic      div_start;  // launch serial divide of the selected magnitude
    logic      div_wait;   // waiting on the divider, store quotient on done
    div_sel_e  div_sel;
    logic      emit;       // load the result registers
  } dp_cmd_t;

  typedef struct packed {
    logic degen;     // both points coincide
    logic gcd_done;
    logic div_done;
  } dp_sts_t;

endpackage

// ----- sv/clfp_gcd.sv -----
// Iterative binary gcd unit, one Stein step per cycle.
// Standalone; no package dependency.
module clfp_gcd #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] u_i,
  input  logic [W-1:0] v_i,
  output logic         done_o,
  output logic [W-1:0] g_o
);

  localparam int KW = $clog2(W + 1);

  logic [W-1:0]  u_q, v_q, g_q;
  logic [KW-1:0] k_q;
  logic          run_q, done_q;
  logic          finish;
  logic [W-1:0]  fin_val;

  // Done when one side is zero or both match; the common factor of two is in k
  assign finish  = run_q && ((u_q == '0) || (v_q == '0) || (u_q == v_q));
  assign fin_val = (u_q == '0) ? v_q : u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= finish && !start_i;
      if (start_i) begin
        run_q <= 1'b1;
      end else if (finish) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= u_i;
      v_q <= v_i;
      k_q <= '0;
    end else if (run_q && !finish) begin
      priority if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + KW'(1);
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q > v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
    if (finish) begin
      g_q <= fin_val << k_q;
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

// ----- sv/clfp_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Standalone; no package dependency.
module clfp_div #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    rem_q, quo_q, d_q;
  logic [CNTW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [W:0]      trial;
  logic [W+1:0]    diff;
  logic            fits;
  logic            last;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_q};
  assign fits  = !diff[W+1];
  assign last  = run_q && (cnt_q == CNTW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last && !start_i;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNTW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (last) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Dividend shifts out of quo_q as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      d_q   <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- sv/clfp_dp.sv -----
// Datapath: point registers, cross products, sign normalization, gcd and
// divider units, result registers. Uses clfp_pkg, clfp_gcd, clfp_div.
module clfp_dp #(
  parameter int CW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic signed [CW-1:0]  first_x_i,
  input  logic signed [CW-1:0]  first_y_i,
  input  logic signed [CW-1:0]  second_x_i,
  input  logic signed [CW-1:0]  second_y_i,
  input  clfp_pkg::dp_cmd_t     cmd_i,
  output clfp_pkg::dp_sts_t     sts_o,
  output logic        [CW-1:0]  coef_a_o,
  output logic signed [CW:0]    coef_b_o,
  output logic signed [2*CW:0]  coef_c_o,
  output logic                  degenerate_o
);

  localparam int GW = 2 * CW;

  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic signed [GW-1:0] p1_q, p2_q;
  logic signed [CW:0]   a_q, b_q;
  logic signed [GW:0]   c_q;
  logic [CW-1:0]        ma_q, mb_q, qa_q, qb_q;
  logic [GW-1:0]        mc_q, qc_q;
  logic                 sb_q, sc_q;

  logic                 degen, neg;
  logic signed [CW:0]   abs_a, abs_b;
  logic signed [GW:0]   abs_c;
  logic                 gcd_start, gcd_done, div_done;
  logic [GW-1:0]        gcd_u, gcd_v, gcd_g, div_n, quot;
  logic signed [CW:0]   qb_s;
  logic signed [GW:0]   qc_s;

  assign degen = (a_q == '0) && (b_q == '0);
  // Canonical sign: a > 0, or a == 0 and b > 0
  assign neg   = a_q[CW] || ((a_q == '0) && b_q[CW]);
  assign abs_a = a_q[CW] ? -a_q : a_q;
  assign abs_b = b_q[CW] ? -b_q : b_q;
  assign abs_c = c_q[GW] ? -c_q : c_q;

  assign gcd_start = cmd_i.g1_start || cmd_i.g2_start;
  assign gcd_u     = cmd_i.g2_start ? gcd_g : GW'(ma_q);
  assign gcd_v     = cmd_i.g2_start ? mc_q  : GW'(mb_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      clfp_pkg::SEL_A: div_n = GW'(ma_q);
      clfp_pkg::SEL_B: div_n = GW'(mb_q);
      clfp_pkg::SEL_C: div_n = mc_q;
      default:         div_n = '0;
    endcase
  end

  assign qb_s = $signed({1'b0, qb_q});
  assign qc_s = $signed({1'b0, qc_q});

  clfp_gcd #(.W(GW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .u_i     (gcd_u),
    .v_i     (gcd_v),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  clfp_div #(.W(GW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_n),
    .divisor_i  (gcd_g),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q <= first_x_i;
      y1_q <= first_y_i;
      x2_q <= second_x_i;
      y2_q <= second_y_i;
    end
    if (cmd_i.mul) begin
      p1_q <= GW'(x1_q) * GW'(y2_q);
      p2_q <= GW'(x2_q) * GW'(y1_q);
      a_q  <= (CW+1)'(y1_q) - (CW+1)'(y2_q);
      b_q  <= (CW+1)'(x2_q) - (CW+1)'(x1_q);
    end
    if (cmd_i.diff) begin
      c_q <= (GW+1)'(p1_q) - (GW+1)'(p2_q);
    end
    if (cmd_i.flip) begin
      ma_q <= abs_a[CW-1:0];
      mb_q <= abs_b[CW-1:0];
      mc_q <= abs_c[GW-1:0];
      sb_q <= b_q[CW] ^ neg;
      sc_q <= c_q[GW] ^ neg;
    end
    if (cmd_i.div_wait && div_done) begin
      unique case (cmd_i.div_sel)
        clfp_pkg::SEL_A: qa_q <= quot[CW-1:0];
        clfp_pkg::SEL_B: qb_q <= quot[CW-1:0];
        clfp_pkg::SEL_C: qc_q <= quot;
        default: ;
      endcase
    end
    if (cmd_i.emit) begin
      if (degen) begin
        coef_a_o     <= '0;
        coef_b_o     <= '0;
        coef_c_o     <= '0;
        degenerate_o <= 1'b1;
      end else begin
        coef_a_o     <= qa_q;
        coef_b_o     <= sb_q ? -qb_s : qb_s;
        coef_c_o     <= sc_q ? -qc_s : qc_s;
        degenerate_o <= 1'b0;
      end
    end
  end

  assign sts_o.degen    = degen;
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_done = div_done;

endmodule

// ----- sv/clfp_ctrl.sv -----
// Sequencer for the canonical line core: steps the datapath through
// products, normalization, two gcd runs and three divides. Uses clfp_pkg.
module clfp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  clfp_pkg::dp_sts_t sts_i,
  output clfp_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DIFF,
    S_FLIP,
    S_G1,
    S_G1W,
    S_G2,
    S_G2W,
    S_DIV,
    S_DIVW,
    S_EMIT
  } state_e;

  state_e             state_q;
  clfp_pkg::div_sel_e sel_q;
  logic               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= clfp_pkg::SEL_A;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) state_q <= S_MUL;
        S_MUL:  state_q <= S_DIFF;
        S_DIFF: state_q <= S_FLIP;
        S_FLIP: state_q <= sts_i.degen ? S_EMIT : S_G1;
        S_G1:   state_q <= S_G1W;
        S_G1W:  if (sts_i.gcd_done) state_q <= S_G2;
        S_G2:   state_q <= S_G2W;
        S_G2W: begin
          if (sts_i.gcd_done) begin
            sel_q   <= clfp_pkg::SEL_A;
            state_q <= S_DIV;
          end
        end
        S_DIV:  state_q <= S_DIVW;
        S_DIVW: begin
          if (sts_i.div_done) begin
            unique case (sel_q)
              clfp_pkg::SEL_A: begin
                sel_q   <= clfp_pkg::SEL_B;
                state_q <= S_DIV;
              end
              clfp_pkg::SEL_B: begin
                sel_q   <= clfp_pkg::SEL_C;
                state_q <= S_DIV;
              end
              default: state_q <= S_EMIT;
            endcase
          end
        end
        S_EMIT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.div_sel   = sel_q;
    cmd_o.load      = (state_q == S_IDLE) && start;
    cmd_o.mul       = (state_q == S_MUL);
    cmd_o.diff      = (state_q == S_DIFF);
    cmd_o.flip      = (state_q == S_FLIP);
    cmd_o.g1_start  = (state_q == S_G1);
    cmd_o.g2_start  = (state_q == S_G2);
    cmd_o.div_start = (state_q == S_DIV);
    cmd_o.div_wait  = (state_q == S_DIVW);
    cmd_o.emit      = (state_q == S_EMIT);
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ----- sv/canonical_line_from_points_core.sv -----
// Canonical line core, top level: joins the sequencer and the datapath.
// Uses clfp_pkg, clfp_ctrl, clfp_dp (which holds clfp_gcd and clfp_div).
//
// Usage:
//   Drive the four point coordinates and raise start while busy is low; the
//   item is taken at that clock edge. busy stays high until the result is out.
//   The result (coef_a_o, coef_b_o, coef_c_o, degenerate_o) appears with
//   done_o high for exactly one cycle; the receiver must take it then, it
//   cannot hold the core off. The result ports keep their value until the
//   next done_o. busy drops in the done_o cycle, so start may be raised then.
// Sequencing, one item at a time:
//   The edge that takes the result is also the earliest edge for the next
//   item. The two binary gcd runs take a data dependent number of Stein steps,
//   one Stein step per cycle. The three restoring divides by the gcd produce
//   one quotient bit per cycle on a 2*COORD_BITS wide dividend. Coincident
//   points skip the gcd and divides and finish with degenerate_o set.
// Reset:
//   rst_ni low returns the sequencer to idle; no clearing pass is needed.
module canonical_line_from_points_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  output logic                          done_o,
  output logic        [COORD_BITS-1:0]  coef_a_o,
  output logic signed [COORD_BITS:0]    coef_b_o,
  output logic signed [2*COORD_BITS:0]  coef_c_o,
  output logic                          degenerate_o
);

  clfp_pkg::dp_cmd_t cmd;
  clfp_pkg::dp_sts_t sts;

  // Sequencer: one state per datapath step, waits on gcd and divider done
  clfp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Datapath: a = y1 - y2, b = x2 - x1, c = x1*y2 - x2*y1, sign fix,
  // g = gcd(gcd(|a|,|b|),|c|), then each magnitude divided by g
  clfp_dp #(.CW(COORD_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .coef_a_o     (coef_a_o),
    .coef_b_o     (coef_b_o),
    .coef_c_o     (coef_c_o),
    .degenerate_o (degenerate_o)
  );

  // Result strobe falls in an idle cycle and is never held high
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done_o while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held two cycles");

  // A taken item keeps the core busy on the next cycle
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("item taken but not busy");

  // Coincident points give all zero coefficients
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> ((coef_a_o == '0) && (coef_b_o == '0)
                                  && (coef_c_o == '0)))
    else $error("degenerate result with nonzero coefficients");

  // Canonical sign: when a is zero, b must be strictly positive
  a_sign_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !degenerate_o && (coef_a_o == '0)) |-> (coef_b_o > 0))
    else $error("coef_b not positive with zero coef_a");

endmodule
